### rtl/whe_pkg.sv
// ----------------------------------------------------------------------------
// whe_pkg
// Shared types and constants for the waypoint heading error pipeline.
// ----------------------------------------------------------------------------
package whe_pkg;

  // Magnitude widths of the position deltas.
  localparam int unsigned LAT_MAG_W = 32;
  localparam int unsigned LON_MAG_W = 33;

  // CORDIC datapath: fraction bits, growth headroom and sign.
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned XY_W   = LON_MAG_W + FRAC_W + 3;
  localparam int unsigned Z_W    = 32;

  // Angle of the first quadrant in hundredths of a degree (0 to 9000).
  localparam int unsigned PHI_W = 14;

  // Angle accumulator unit is 1/6553600 degree.
  localparam logic signed [Z_W-1:0] QUARTER_TURN_Z = 32'sd589824000;
  localparam logic signed [Z_W-1:0] ROUND_HALF_Z   = 32'sd32768;
  localparam int unsigned           Z_FRAC_W       = 16;

  // Angles in hundredths of a degree.
  localparam logic [PHI_W-1:0] QUARTER_TURN_H = 14'd9000;
  localparam logic [15:0]      HALF_TURN_H    = 16'd18000;
  localparam logic [15:0]      FULL_TURN_H    = 16'd36000;

  // Entry k is atan(2^-k) in accumulator units, rounded to nearest.
  localparam logic [Z_W-1:0] ATAN_TABLE [32] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507,
    32'd23437865,  32'd11730358,  32'd5866610,  32'd2933484,
    32'd1466764,   32'd733385,    32'd366693,   32'd183346,
    32'd91673,     32'd45837,     32'd22918,    32'd11459,
    32'd5730,      32'd2865,      32'd1432,     32'd716,
    32'd358,       32'd179,       32'd90,       32'd45,
    32'd22,        32'd11,        32'd6,        32'd3,
    32'd1,         32'd1,         32'd0,        32'd0
  };

  // Per-beat side information that travels alongside the CORDIC data.
  typedef struct packed {
    logic        neg_lat;   // target lies south
    logic        neg_lon;   // target lies west
    logic        lat_zero;  // north delta is zero
    logic        lon_zero;  // east delta is zero
    logic [15:0] heading;   // present heading
  } whe_side_t;

endpackage

### rtl/whe_cordic.sv
// ----------------------------------------------------------------------------
// whe_cordic
// Unrolled CORDIC in vectoring mode, one register stage per iteration.
// ----------------------------------------------------------------------------
module whe_cordic import whe_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [LAT_MAG_W-1:0]  north_i,
  input  logic [LON_MAG_W-1:0]  east_i,
  input  whe_side_t             side_i,
  output logic                  valid_o,
  output logic signed [Z_W-1:0] z_o,
  output whe_side_t             side_o
);

  logic                  v_q    [CORDIC_STAGES];
  logic signed [XY_W-1:0] x_q   [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q   [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q   [CORDIC_STAGES];
  whe_side_t              side_q [CORDIC_STAGES];

  // Scaled start vector: the deltas with the fraction bits appended.
  logic signed [XY_W-1:0] x_init, y_init;

  assign x_init = $signed({{(XY_W-LAT_MAG_W-FRAC_W){1'b0}}, north_i, {FRAC_W{1'b0}}});
  assign y_init = $signed({{(XY_W-LON_MAG_W-FRAC_W){1'b0}}, east_i, {FRAC_W{1'b0}}});

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic                   v_c;
    logic signed [XY_W-1:0] x_c, y_c, x_sh, y_sh, x_d, y_d;
    logic signed [Z_W-1:0]  z_c, z_d;
    whe_side_t              s_c;

    // Stage input comes from the ports or from the previous stage.
    if (i == 0) begin : g_first
      assign v_c = valid_i;
      assign x_c = x_init;
      assign y_c = y_init;
      assign z_c = '0;
      assign s_c = side_i;
    end else begin : g_next
      assign v_c = v_q[i-1];
      assign x_c = x_q[i-1];
      assign y_c = y_q[i-1];
      assign z_c = z_q[i-1];
      assign s_c = side_q[i-1];
    end

    // One micro-rotation toward the x axis; shifts round toward minus infinity.
    always_comb begin
      x_sh = x_c >>> i;
      y_sh = y_c >>> i;
      if (!y_c[XY_W-1]) begin
        x_d = x_c + y_sh;
        y_d = y_c - x_sh;
        z_d = z_c + $signed(ATAN_TABLE[i]);
      end else begin
        x_d = x_c - y_sh;
        y_d = y_c + x_sh;
        z_d = z_c - $signed(ATAN_TABLE[i]);
      end
    end

    // Valid bit of this stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_c;
      end
    end

    // Data of this stage.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= x_d;
        y_q[i]    <= y_d;
        z_q[i]    <= z_d;
        side_q[i] <= s_c;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign z_o     = z_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

### rtl/waypoint_heading_error.sv
// A beat passes the input register, the CORDIC stages, then the angle, bearing and output registers.
// Throughput: one beat per cycle while the output is not stalled; one register stage per CORDIC iteration.
// The whole pipeline advances together and holds while the output waits.
// Reset clears every valid bit at once; data registers are not reset.
// ----------------------------------------------------------------------------
// waypoint_heading_error
// Bearing from the current to the next GPS position through a pipelined
// CORDIC arctangent, and the heading error wrapped into [-180, 180) degrees.
// ----------------------------------------------------------------------------
module waypoint_heading_error import whe_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [30:0] cur_latitude_i,
  input  logic signed [31:0] cur_longitude_i,
  input  logic signed [30:0] next_latitude_i,
  input  logic signed [31:0] next_longitude_i,
  input  logic [15:0]        heading_now_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        bearing_o,
  output logic signed [15:0] heading_error_o
);

  localparam logic signed [18:0] FULL_TURN_S  = 19'sd36000;
  localparam logic signed [18:0] DOUBLE_TURN_S = 19'sd72000;
  localparam logic signed [18:0] HALF_TURN_S  = 19'sd18000;

  logic en;

  // Pipeline advances when the output register is empty or being drained.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage: deltas, magnitudes and quadrant flags.
  // --------------------------------------------------------------------------
  logic signed [31:0]    dlat;
  logic signed [32:0]    dlon;
  logic [LAT_MAG_W-1:0]  north_d, north_q;
  logic [LON_MAG_W-1:0]  east_d, east_q;
  whe_side_t             prep_side_d, prep_side_q;
  logic                  prep_v_q;

  always_comb begin
    dlat = $signed({next_latitude_i[30], next_latitude_i})
         - $signed({cur_latitude_i[30], cur_latitude_i});
    dlon = $signed({next_longitude_i[31], next_longitude_i})
         - $signed({cur_longitude_i[31], cur_longitude_i});
    north_d = dlat[31] ? LAT_MAG_W'(-dlat) : LAT_MAG_W'(dlat);
    east_d  = dlon[32] ? LON_MAG_W'(-dlon) : LON_MAG_W'(dlon);
    prep_side_d.neg_lat  = dlat[31];
    prep_side_d.neg_lon  = dlon[32];
    prep_side_d.lat_zero = (dlat == '0);
    prep_side_d.lon_zero = (dlon == '0);
    prep_side_d.heading  = heading_now_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      north_q     <= north_d;
      east_q      <= east_d;
      prep_side_q <= prep_side_d;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC iterations.
  // --------------------------------------------------------------------------
  logic                  cor_v;
  logic signed [Z_W-1:0] cor_z;
  whe_side_t             cor_side;

  whe_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(prep_v_q),
    .north_i(north_q),
    .east_i (east_q),
    .side_i (prep_side_q),
    .valid_o(cor_v),
    .z_o    (cor_z),
    .side_o (cor_side)
  );

  // --------------------------------------------------------------------------
  // Stage: clamp, round to hundredths, exact axis cases.
  // --------------------------------------------------------------------------
  logic signed [Z_W-1:0] z_clamp, z_round;
  logic [PHI_W-1:0]      phi_d, phi_q;
  whe_side_t             phi_side_q;
  logic                  phi_v_q;

  always_comb begin
    if (cor_z[Z_W-1]) begin
      z_clamp = '0;
    end else if (cor_z > QUARTER_TURN_Z) begin
      z_clamp = QUARTER_TURN_Z;
    end else begin
      z_clamp = cor_z;
    end
    z_round = z_clamp + ROUND_HALF_Z;
    if (cor_side.lon_zero) begin
      phi_d = '0;
    end else if (cor_side.lat_zero) begin
      phi_d = QUARTER_TURN_H;
    end else begin
      phi_d = z_round[Z_FRAC_W +: PHI_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phi_v_q <= 1'b0;
    end else if (en) begin
      phi_v_q <= cor_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q      <= phi_d;
      phi_side_q <= cor_side;
    end
  end

  // --------------------------------------------------------------------------
  // Stage: fold the quadrant angle into a compass bearing.
  // --------------------------------------------------------------------------
  logic [15:0] phi_ext, brg_raw, brg_d, brg_q, brg_head_q;
  logic        brg_v_q;

  always_comb begin
    phi_ext = {{(16-PHI_W){1'b0}}, phi_q};
    if (!phi_side_q.neg_lat && !phi_side_q.neg_lon) begin
      brg_raw = phi_ext;
    end else if (phi_side_q.neg_lat && !phi_side_q.neg_lon) begin
      brg_raw = HALF_TURN_H - phi_ext;
    end else if (phi_side_q.neg_lat) begin
      brg_raw = HALF_TURN_H + phi_ext;
    end else begin
      brg_raw = FULL_TURN_H - phi_ext;
    end
    brg_d = (brg_raw >= FULL_TURN_H) ? brg_raw - FULL_TURN_H : brg_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brg_v_q <= 1'b0;
    end else if (en) begin
      brg_v_q <= phi_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      brg_q      <= brg_d;
      brg_head_q <= phi_side_q.heading;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: heading error reduced modulo a full turn.
  // --------------------------------------------------------------------------
  logic signed [18:0] diff, err_pos, err_wrap;
  logic               out_v_q;
  logic [15:0]        bearing_q;
  logic signed [15:0] heading_error_q;

  always_comb begin
    diff = $signed({3'b000, brg_q}) - $signed({3'b000, brg_head_q});
    if (diff < -FULL_TURN_S) begin
      err_pos = diff + DOUBLE_TURN_S;
    end else if (diff < 19'sd0) begin
      err_pos = diff + FULL_TURN_S;
    end else begin
      err_pos = diff;
    end
    err_wrap = (err_pos >= HALF_TURN_S) ? err_pos - FULL_TURN_S : err_pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= brg_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bearing_q       <= brg_q;
      heading_error_q <= err_wrap[15:0];
    end
  end

  assign out_valid_o     = out_v_q;
  assign bearing_o       = bearing_q;
  assign heading_error_o = heading_error_q;

`ifndef ASSERT_OFF
  // A delivered bearing never reaches a full turn.
  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bearing_o < FULL_TURN_H))
    else $error("bearing out of range");

  // A delivered heading error lies in [-18000, 17999].
  a_error_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_error_o >= -16'sd18000 && heading_error_o < 16'sd18000))
    else $error("heading error out of range");

  // The rounded quadrant angle never exceeds a quarter turn.
  a_phi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phi_v_q |-> (phi_q <= QUARTER_TURN_H))
    else $error("quadrant angle out of range");

  // While a result waits, the pipeline is frozen and the CORDIC keeps its beat.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (cor_v == $past(cor_v) && phi_v_q == $past(phi_v_q)))
    else $error("pipeline moved during a stall");
`endif

endmodule
